FILE: src/rwc_pkg.sv
// Package: shared constants for the rolling window checksum block.
`timescale 1ns / 1ps

package rwc_pkg;

    // Default sizing of the window store and of the sums
    localparam int MAX_BLOCK_DEF = 4096;
    localparam int MOD_BITS_DEF  = 16;

    // Fixed field widths
    localparam int BYTE_W      = 8;
    localparam int BLEN_W      = 13;
    localparam int CHECKSUM_W  = 32;
    localparam int SUM_OUT_W   = 16;
    localparam int PROD_W      = BLEN_W + BYTE_W;

    // Configuration port
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_LSB = 2;
    localparam int REG_IDX_W   = PADDR_W - REG_IDX_LSB;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_BLOCK_LENGTH = '0;

    // Reset value of block_length
    localparam logic [BLEN_W-1:0] BLOCK_LENGTH_RESET = 13'd1024;

endpackage

FILE: src/rwc_if.sv
// Interfaces: input and result channels of the rolling window checksum block.
`timescale 1ns / 1ps

interface rwc_in_if
    import rwc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] new_byte;
    logic              restart;

    modport source (output valid, output new_byte, output restart, input ready);
    modport sink   (input valid, input new_byte, input restart, output ready);
endinterface

interface rwc_out_if
    import rwc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CHECKSUM_W-1:0] checksum;
    logic [SUM_OUT_W-1:0]  sum_a;
    logic [SUM_OUT_W-1:0]  sum_b;
    logic                  window_full;

    modport source (output valid, output checksum, output sum_a, output sum_b,
                    output window_full, input ready);
    modport sink   (input valid, input checksum, input sum_a, input sum_b,
                    input window_full, output ready);
endinterface

FILE: src/rwc_window_mem.sv
// Window store: single-port synchronous byte memory, read-first, registered read data.
`timescale 1ns / 1ps

module rwc_window_mem
    import rwc_pkg::*;
#(
    parameter int DEPTH  = MAX_BLOCK_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [BYTE_W-1:0] wdata,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    // Read the leaving byte and write the entering byte at the same slot
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/rolling_window_checksum_core.sv
// Top level: rolling window checksum core with window store, sum update and APB register.
`timescale 1ns / 1ps

// Takes one byte per clock cycle and returns one result per byte: the rolling
// sums a and b of the last block_length bytes and their packed checksum
// a + b*2^MOD_BITS. Sustained rate is one item per cycle while out_ch.ready
// does not hold the output register; each byte passes stage 1, where the
// window store read of the leaving byte is registered, then the sum update
// into the output register. The window store is a single-port read-first
// memory that is read and written at the same slot in the accept cycle, so no
// clearing pass runs after reset and the block accepts items at once. Setting
// restart on an item clears the sums and the fill count before that byte
// enters. block_length lies at byte address 0 of the APB port; 0 acts as 1 and
// values above MAX_BLOCK act as MAX_BLOCK. Write it only while the block is idle.
module rolling_window_checksum_core
    import rwc_pkg::*;
#(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF,
    parameter int MOD_BITS  = MOD_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    rwc_in_if.sink             in_ch,
    rwc_out_if.source          out_ch
);

    localparam int ADDR_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

    // Configuration register
    logic [BLEN_W-1:0]    block_length_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    // Window control state
    logic [ADDR_W-1:0] ptr_reg;
    logic [ADDR_W-1:0] ptr_next;
    logic [BLEN_W-1:0] fill_reg;
    logic [BLEN_W-1:0] fill_next;

    // Stage 1: item waiting on the store read
    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_restart_reg;
    logic              s1_old_valid_reg;
    logic              s1_full_reg;
    logic [BLEN_W-1:0] s1_len_reg;

    // Running sums
    logic [MOD_BITS-1:0] a_reg;
    logic [MOD_BITS-1:0] b_reg;
    logic [MOD_BITS-1:0] a_next;
    logic [MOD_BITS-1:0] b_next;

    // Output register
    logic                  out_valid_reg;
    logic [CHECKSUM_W-1:0] out_checksum_reg;
    logic [SUM_OUT_W-1:0]  out_sum_a_reg;
    logic [SUM_OUT_W-1:0]  out_sum_b_reg;
    logic                  out_full_reg;

    logic              in_fire;
    logic              s1_adv;
    logic [BLEN_W-1:0] len_eff;
    logic [ADDR_W-1:0] ptr_eff;
    logic [BLEN_W-1:0] fill_eff;
    logic              old_valid;
    logic              full_now;
    logic [31:0]       ptr_inc;
    logic [BYTE_W-1:0] mem_rdata;
    logic [BYTE_W-1:0] old_byte;
    logic [MOD_BITS-1:0] a_base;
    logic [MOD_BITS-1:0] b_base;
    logic [PROD_W-1:0]   prod;

    // Decode and write the configuration register
    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:REG_IDX_LSB];
    assign cfg_write = psel && penable && pwrite && pready && (reg_idx == REG_BLOCK_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_length_reg <= BLOCK_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            block_length_reg <= pwdata[BLEN_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_BLOCK_LENGTH)
        begin
            prdata = {{(PDATA_W-BLEN_W){1'b0}}, block_length_reg};
        end
    end

    // Clamp the window length
    always_comb
    begin
        if (block_length_reg == '0)
        begin
            len_eff = BLEN_W'(1);
        end
        else if (32'(block_length_reg) > MAX_BLOCK)
        begin
            len_eff = BLEN_W'(MAX_BLOCK);
        end
        else
        begin
            len_eff = block_length_reg;
        end
    end

    // Handshake: stage 1 moves on when the output register is free or drains
    assign s1_adv      = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_adv;
    assign in_fire     = in_ch.valid && in_ch.ready;

    // Pick the slot and the fill state for the entering byte
    always_comb
    begin
        ptr_eff  = ptr_reg;
        fill_eff = fill_reg;
        if (in_ch.restart)
        begin
            ptr_eff  = '0;
            fill_eff = '0;
        end
        if (32'(ptr_eff) >= 32'(len_eff))
        begin
            ptr_eff = '0;
        end
        old_valid = (fill_eff >= len_eff);
        fill_next = old_valid ? fill_eff : fill_eff + BLEN_W'(1);
        full_now  = (fill_next >= len_eff);
        ptr_inc   = 32'(ptr_eff) + 32'd1;
        ptr_next  = (ptr_inc >= 32'(len_eff)) ? '0 : ptr_inc[ADDR_W-1:0];
    end

    // Advance the slot pointer and the fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            fill_reg <= '0;
        end
        else if (in_fire)
        begin
            ptr_reg  <= ptr_next;
            fill_reg <= fill_next;
        end
    end

    rwc_window_mem #(
        .DEPTH  (MAX_BLOCK),
        .ADDR_W (ADDR_W)
    ) u_window_mem (
        .clk   (clk),
        .en    (in_fire),
        .addr  (ptr_eff),
        .wdata (in_ch.new_byte),
        .rdata (mem_rdata)
    );

    // Stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg      <= in_ch.new_byte;
            s1_restart_reg   <= in_ch.restart;
            s1_old_valid_reg <= old_valid;
            s1_full_reg      <= full_now;
            s1_len_reg       <= len_eff;
        end
    end

    // Roll the sums: drop the leaving byte, add the entering byte
    always_comb
    begin
        old_byte = s1_old_valid_reg ? mem_rdata : '0;
        a_base   = s1_restart_reg ? '0 : a_reg;
        b_base   = s1_restart_reg ? '0 : b_reg;
        prod     = PROD_W'(s1_len_reg) * PROD_W'(old_byte);
        a_next   = a_base - MOD_BITS'(old_byte) + MOD_BITS'(s1_byte_reg);
        b_next   = b_base - prod[MOD_BITS-1:0] + a_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
        end
        else if (s1_adv)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    // Output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_checksum_reg <= CHECKSUM_W'(a_next) | (CHECKSUM_W'(b_next) << MOD_BITS);
            out_sum_a_reg    <= SUM_OUT_W'(a_next);
            out_sum_b_reg    <= SUM_OUT_W'(b_next);
            out_full_reg     <= s1_full_reg;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.checksum    = out_checksum_reg;
    assign out_ch.sum_a       = out_sum_a_reg;
    assign out_ch.sum_b       = out_sum_b_reg;
    assign out_ch.window_full = out_full_reg;

`ifndef ASSERT_OFF
    // A stalled stage 1 keeps the leaving byte it read
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv && s1_old_valid_reg) |=> $stable(mem_rdata))
        else $error("window store read data changed under a stalled item");

    // A restarted item leaves exactly one byte counted in the window
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_ch.restart) |=> (fill_reg == BLEN_W'(1)))
        else $error("fill count wrong after restart");

    // The fill count never passes the store depth
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= MAX_BLOCK)
        else $error("fill count beyond store depth");

    // Every item leaving stage 1 lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("item lost between stage 1 and output register");
`endif

endmodule
